[hw/rtl/itrd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// itrd_pkg
// shared constants, types, the digit-to-ascii and buffer address mappings of the radix converter
// ----------------------------------------------------------------------------
package itrd_pkg;

	// value and digit sizing
	localparam int VALUE_BITS  = 32;
	localparam int MAX_DIGITS  = 32;
	localparam int RADIX_W     = 6;
	localparam int DIGIT_W     = 6;
	localparam int CHAR_W      = 7;

	// radix register
	localparam int           APB_DATA_W  = 32;
	localparam int           PADDR_W     = 3;
	localparam logic [0:0]   REG_RADIX   = 1'b0;
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

	// divide unit: quotient bits retired per cycle
	localparam int STEPS_PER_CYCLE = 4;
	localparam int DIV_W           = ((VALUE_BITS + STEPS_PER_CYCLE - 1) / STEPS_PER_CYCLE)
		* STEPS_PER_CYCLE;
	localparam int DIV_CYCLES      = DIV_W / STEPS_PER_CYCLE;
	localparam int STEP_CNT_W      = $clog2(DIV_CYCLES);

	// digit buffer: two banks of MAX_DIGITS entries
	localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W     = $clog2(MAX_DIGITS);
	localparam int RAM_DEPTH = 2 * MAX_DIGITS;
	localparam int ADDR_W    = $clog2(RAM_DEPTH);

	// output queue
	localparam int OFIFO_DEPTH = 4;
	localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
	localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

	// ascii
	localparam logic [CHAR_W-1:0]  ASCII_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0]  ASCII_A     = CHAR_W'(65);
	localparam logic [DIGIT_W-1:0] DECIMAL_MAX = DIGIT_W'(9);
	localparam logic [DIGIT_W-1:0] DECIMAL_TEN = DIGIT_W'(10);

	// finished conversion handed from front to back
	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] count;
	} job_t;

	typedef struct packed {
		logic             push;
		logic [CNT_W-1:0] count;
	} job_push_t;

	typedef struct packed {
		logic full;
		logic wr_bank;
	} job_qstat_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_head_t;

	function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d <= DECIMAL_MAX) begin
			c = ASCII_ZERO + CHAR_W'(d);
		end else begin
			c = ASCII_A + CHAR_W'(d - DECIMAL_TEN);
		end
		return c;
	endfunction

	function automatic logic [ADDR_W-1:0] buf_addr(input logic bank,
		input logic [IDX_W-1:0] idx);
		logic [ADDR_W-1:0] a;
		a = ADDR_W'(idx);
		if (bank) begin
			a = a + ADDR_W'(MAX_DIGITS);
		end
		return a;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/itrd_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// itrd_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module itrd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[hw/rtl/itrd_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// itrd_front
// accepts a value and divides it repeatedly by the radix, storing remainders
// ----------------------------------------------------------------------------
module itrd_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	input  wire logic [itrd_pkg::VALUE_BITS-1:0]   value_in,
	input  wire logic [itrd_pkg::RADIX_W-1:0]      radix,
	input  wire itrd_pkg::job_qstat_t              qstat,
	output logic                                   full,
	output itrd_pkg::job_push_t                    job_push,
	output logic                                   ram_we,
	output logic [itrd_pkg::ADDR_W-1:0]            ram_waddr,
	output logic [itrd_pkg::DIGIT_W-1:0]           ram_wdata
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic                               state_q;
	logic [itrd_pkg::DIV_W-1:0]         quo_q;
	logic [itrd_pkg::RADIX_W-1:0]       rem_q;
	logic [itrd_pkg::RADIX_W-1:0]       base_q;
	logic [itrd_pkg::STEP_CNT_W-1:0]    step_q;
	logic [itrd_pkg::CNT_W-1:0]         ndig_q;
	logic                               bank_q;

	logic [itrd_pkg::DIV_W-1:0]         quo_c;
	logic [itrd_pkg::RADIX_W-1:0]       rem_c;
	logic [itrd_pkg::CNT_W-1:0]         ndig_next;
	logic                               digit_end;
	logic                               job_done;
	logic                               accept;

	// restoring division, STEPS_PER_CYCLE quotient bits per cycle
	always_comb begin
		logic [itrd_pkg::RADIX_W:0] t;
		quo_c = quo_q;
		rem_c = rem_q;
		for (int i = 0; i < itrd_pkg::STEPS_PER_CYCLE; i++) begin
			t     = {rem_c, quo_c[itrd_pkg::DIV_W-1]};
			quo_c = {quo_c[itrd_pkg::DIV_W-2:0], 1'b0};
			if (t >= {1'b0, base_q}) begin
				t        = t - {1'b0, base_q};
				quo_c[0] = 1'b1;
			end
			rem_c = t[itrd_pkg::RADIX_W-1:0];
		end
	end

	assign digit_end = (step_q == itrd_pkg::STEP_CNT_W'(itrd_pkg::DIV_CYCLES - 1));
	assign ndig_next = ndig_q + itrd_pkg::CNT_W'(1);
	assign job_done  = digit_end && ((quo_c == '0) ||
		(ndig_next == itrd_pkg::CNT_W'(itrd_pkg::MAX_DIGITS)));

	assign full   = (state_q == ST_DIV) || qstat.full;
	assign accept = push && !full;

	assign ram_we    = (state_q == ST_DIV) && digit_end;
	assign ram_waddr = itrd_pkg::buf_addr(bank_q, ndig_q[itrd_pkg::IDX_W-1:0]);
	assign ram_wdata = rem_c;

	assign job_push.push  = (state_q == ST_DIV) && job_done;
	assign job_push.count = ndig_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			ndig_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
						step_q  <= '0;
						ndig_q  <= '0;
					end
				end
				ST_DIV: begin
					step_q <= step_q + itrd_pkg::STEP_CNT_W'(1);
					if (digit_end) begin
						step_q <= '0;
						ndig_q <= ndig_next;
						if (job_done) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			quo_q  <= itrd_pkg::DIV_W'(value_in);
			rem_q  <= '0;
			base_q <= radix;
			bank_q <= qstat.wr_bank;
		end else if (state_q == ST_DIV) begin
			quo_q <= quo_c;
			rem_q <= digit_end ? '0 : rem_c;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/itrd_job_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// itrd_job_queue
// two-entry queue of finished conversions, entry slot doubles as buffer bank
// ----------------------------------------------------------------------------
module itrd_job_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire itrd_pkg::job_push_t   job_push,
	input  wire logic                  job_pop,
	output itrd_pkg::job_qstat_t       qstat,
	output itrd_pkg::job_head_t        head
);

	logic [itrd_pkg::CNT_W-1:0] count_q [2];
	logic                       wr_ptr_q;
	logic                       rd_ptr_q;
	logic [1:0]                 fill_q;

	assign qstat.full     = (fill_q == 2'd2);
	assign qstat.wr_bank  = wr_ptr_q;
	assign head.valid     = (fill_q != 2'd0);
	assign head.job.bank  = rd_ptr_q;
	assign head.job.count = count_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (job_push.push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (job_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({job_push.push, job_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_push.push) begin
			count_q[wr_ptr_q] <= job_push.count;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/itrd_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// itrd_back
// reads stored digits most significant first and queues ascii characters
// ----------------------------------------------------------------------------
module itrd_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire itrd_pkg::job_head_t          head,
	output logic                              job_pop,
	output logic                              ram_re,
	output logic [itrd_pkg::ADDR_W-1:0]       ram_raddr,
	input  wire logic [itrd_pkg::DIGIT_W-1:0] ram_rdata,
	input  wire logic                         pop,
	output logic                              empty,
	output logic [itrd_pkg::CHAR_W-1:0]       digit_char,
	output logic                              last_digit
);

	logic                               active_q;
	logic                               bank_q;
	logic [itrd_pkg::IDX_W-1:0]         idx_q;
	logic                               rd_s1;
	logic                               last_s1;

	logic [itrd_pkg::CHAR_W-1:0]        char_q [itrd_pkg::OFIFO_DEPTH];
	logic                               last_q [itrd_pkg::OFIFO_DEPTH];
	logic [itrd_pkg::OFIFO_PTR_W-1:0]   wp_q;
	logic [itrd_pkg::OFIFO_PTR_W-1:0]   rp_q;
	logic [itrd_pkg::OFIFO_CNT_W-1:0]   cnt_q;

	logic                               issue;
	logic                               do_pop;

	// reserve a slot for the read in flight
	assign issue = active_q &&
		((cnt_q + itrd_pkg::OFIFO_CNT_W'(rd_s1)) < itrd_pkg::OFIFO_CNT_W'(itrd_pkg::OFIFO_DEPTH));
	assign job_pop   = issue && (idx_q == '0);
	assign ram_re    = issue;
	assign ram_raddr = itrd_pkg::buf_addr(bank_q, idx_q);

	assign empty      = (cnt_q == '0);
	assign do_pop     = pop && !empty;
	assign digit_char = char_q[rp_q];
	assign last_digit = last_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			rd_s1    <= 1'b0;
			wp_q     <= '0;
			rp_q     <= '0;
			cnt_q    <= '0;
		end else begin
			if (!active_q && head.valid) begin
				active_q <= 1'b1;
			end else if (job_pop) begin
				active_q <= 1'b0;
			end
			rd_s1 <= issue;
			if (rd_s1) begin
				wp_q <= wp_q + itrd_pkg::OFIFO_PTR_W'(1);
			end
			if (do_pop) begin
				rp_q <= rp_q + itrd_pkg::OFIFO_PTR_W'(1);
			end
			case ({rd_s1, do_pop})
				2'b10:   cnt_q <= cnt_q + itrd_pkg::OFIFO_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - itrd_pkg::OFIFO_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (!active_q && head.valid) begin
			bank_q <= head.job.bank;
			idx_q  <= itrd_pkg::IDX_W'(head.job.count - itrd_pkg::CNT_W'(1));
		end else if (issue) begin
			idx_q <= idx_q - itrd_pkg::IDX_W'(1);
		end
		if (issue) begin
			last_s1 <= (idx_q == '0);
		end
		if (rd_s1) begin
			char_q[wp_q] <= itrd_pkg::to_ascii(ram_rdata);
			last_q[wp_q] <= last_s1;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/integer_to_radix_digits.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// converts an unsigned value to ascii digits in a programmable base 2..36,
// most significant digit first, final digit marked
// ----------------------------------------------------------------------------
//
// channel   | handshake          | payload                 | transfer when
// ----------+--------------------+-------------------------+-----------------------
// input     | push / full        | value_in                | push && !full
// result    | pop / empty        | digit_char, last_digit  | pop && !empty
// config    | psel/penable/...   | paddr, pwdata, prdata   | psel && penable && pwrite
//
// flow: each digit passes through the divide unit at 4 quotient bits per
// cycle over the 32-bit value, and full stays high while a value is being
// divided; the next value transfers once the front is back in idle at the
// earliest; characters leave at one per cycle from the back while pop is held,
// overlapped with the next conversion
// reset: radix returns to 10, both queues empty; the digit buffer holds no reset
// stalls: the front takes a new value while up to one finished value waits in
// the buffer; a stalled result side only fills the output queue and job queue
//
module integer_to_radix_digits (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input queue side
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic [itrd_pkg::VALUE_BITS-1:0]   value_in,
	// result queue side
	input  wire logic                              pop,
	output logic                                   empty,
	output logic [itrd_pkg::CHAR_W-1:0]            digit_char,
	output logic                                   last_digit,
	// register port
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [itrd_pkg::PADDR_W-1:0]      paddr,
	input  wire logic [itrd_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [itrd_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                   pready
);

	logic [itrd_pkg::RADIX_W-1:0] radix_q;
	logic [itrd_pkg::RADIX_W-1:0] wr_radix;
	logic                         reg_sel;
	logic                         reg_wr;

	itrd_pkg::job_qstat_t         qstat;
	itrd_pkg::job_push_t          job_push;
	itrd_pkg::job_head_t          head;
	logic                         job_pop;

	logic                         ram_we;
	logic [itrd_pkg::ADDR_W-1:0]  ram_waddr;
	logic [itrd_pkg::DIGIT_W-1:0] ram_wdata;
	logic                         ram_re;
	logic [itrd_pkg::ADDR_W-1:0]  ram_raddr;
	logic [itrd_pkg::DIGIT_W-1:0] ram_rdata;

	// register access, zero wait states
	assign pready  = 1'b1;
	assign reg_sel = (paddr[itrd_pkg::PADDR_W-1] == itrd_pkg::REG_RADIX);
	assign reg_wr  = psel && penable && pwrite && pready && reg_sel;

	// saturate the written base into 2..36
	always_comb begin
		wr_radix = pwdata[itrd_pkg::RADIX_W-1:0];
		if (wr_radix < itrd_pkg::RADIX_MIN) begin
			wr_radix = itrd_pkg::RADIX_MIN;
		end else if (wr_radix > itrd_pkg::RADIX_MAX) begin
			wr_radix = itrd_pkg::RADIX_MAX;
		end
	end

	assign prdata = reg_sel ? itrd_pkg::APB_DATA_W'(radix_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= itrd_pkg::RADIX_RESET;
		end else if (reg_wr) begin
			radix_q <= wr_radix;
		end
	end

	// front: accept and divide
	itrd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.value_in  (value_in),
		.radix     (radix_q),
		.qstat     (qstat),
		.full      (full),
		.job_push  (job_push),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	// two banks of remainders, one per queued conversion
	itrd_ram #(
		.WIDTH (itrd_pkg::DIGIT_W),
		.DEPTH (itrd_pkg::RAM_DEPTH)
	) u_digit_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// finished conversions waiting for the back
	itrd_job_queue u_job_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_push (job_push),
		.job_pop  (job_pop),
		.qstat    (qstat),
		.head     (head)
	);

	// back: emit characters, most significant first
	itrd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.job_pop    (job_pop),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.pop        (pop),
		.empty      (empty),
		.digit_char (digit_char),
		.last_digit (last_digit)
	);

endmodule
`default_nettype wire

[sim/tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the radix digit converter: a directed table of
// extremes and saturating radix writes, then randomized phases per radix, with
// random idle on both queue sides outside the no-idle phases; every character is checked in order
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import itrd_pkg::*;

	// slowest legal run is 221 values, each with 32 chars under the longest pop
	// stall, the longest push gap and the full divide, well within CYCLE_LIMIT
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int SETTLE_CYCLES = 32;
	localparam int DIR_ROWS     = 21;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_VALUES = 25;
	localparam int MAX_ERR_LINES = 40;

	localparam logic [PADDR_W-1:0] RADIX_ADDR   = {REG_RADIX, 2'b00};
	localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = {~REG_RADIX, 2'b00};

	localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'd48;
	localparam logic [CHAR_W-1:0]  CHAR_LETTER = 7'd65;
	localparam logic [DIGIT_W-1:0] LAST_DECIMAL = 6'd9;
	localparam logic [DIGIT_W-1:0] FIRST_LETTER = 6'd10;

	// one character as it leaves the block
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} digit_xfer_t;

	// directed row: optional register write, then one value; text holds the
	// spelled-out digits where they are obvious, else zero
	typedef struct packed {
		logic               cfg;
		logic [PADDR_W-1:0] addr;
		logic [31:0]        wdata;
		logic [31:0]        value;
		logic [255:0]       text;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   push;
	logic                   full;
	logic [VALUE_BITS-1:0]  value_in;
	logic                   pop;
	logic                   empty;
	logic [CHAR_W-1:0]      digit_char;
	logic                   last_digit;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [PADDR_W-1:0]     paddr;
	logic [APB_DATA_W-1:0]  pwdata;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;

	digit_xfer_t            digits_due[$];
	logic [RADIX_W-1:0]     radix_shadow;
	int                     mismatch_count = 0;
	int                     cycle_count = 0;
	bit                     no_idle = 1'b0;
	dir_row_t               dir_rows [DIR_ROWS];

	integer_to_radix_digits dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.value_in   (value_in),
		.pop        (pop),
		.empty      (empty),
		.digit_char (digit_char),
		.last_digit (last_digit),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d chars still due", cycle_count,
				digits_due.size());
			$display("** integer_to_radix_digits: FAILED **");
			$finish;
		end
	end

	task automatic flag_mismatch(input string msg);
		if (mismatch_count < MAX_ERR_LINES) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
		mismatch_count++;
	endtask

	// append one expected character at the tail
	function automatic void queue_digit(input digit_xfer_t x);
		digits_due = {digits_due, x};
	endfunction

	// repeated division, remainders least significant first, emitted msd first
	function automatic void expand_digits(input logic [31:0] v, input logic [RADIX_W-1:0] base);
		logic [DIGIT_W-1:0] rems [MAX_DIGITS];
		logic [31:0]        quo;
		logic [DIGIT_W-1:0] d;
		digit_xfer_t        x;
		int                 n;
		quo = v;
		n = 0;
		do begin
			rems[n] = DIGIT_W'(quo % 32'(base));
			quo = quo / 32'(base);
			n++;
		end while (quo != 0 && n < MAX_DIGITS);
		for (int k = 0; k < n; k++) begin
			d = rems[n - 1 - k];
			if (d <= LAST_DECIMAL) begin
				x.ch = CHAR_ZERO + CHAR_W'(d);
			end else begin
				x.ch = CHAR_LETTER + CHAR_W'(d - FIRST_LETTER);
			end
			x.last = (k == n - 1);
			queue_digit(x);
		end
	endfunction

	// digits typed into the table, right-justified ascii
	function automatic void load_spelled(input logic [255:0] text);
		digit_xfer_t x;
		int          n;
		n = 0;
		while (n < 32 && text[n*8 +: 8] != 8'd0) begin
			n++;
		end
		for (int k = 0; k < n; k++) begin
			x.ch = text[(n - 1 - k)*8 +: CHAR_W];
			x.last = (k == n - 1);
			queue_digit(x);
		end
	endfunction

	function automatic dir_row_t mk_row(input logic cfg, input logic [PADDR_W-1:0] addr,
		input logic [31:0] wdata, input logic [31:0] value, input logic [255:0] text);
		dir_row_t r;
		r.cfg = cfg;
		r.addr = addr;
		r.wdata = wdata;
		r.value = value;
		r.text = text;
		return r;
	endfunction

	// mix of corners, small values, values around powers of the base and plain random words
	function automatic logic [31:0] random_value(input logic [RADIX_W-1:0] base);
		logic [63:0] p;
		logic [31:0] v;
		int          k;
		case ($urandom_range(0, 7))
			0: begin
				v = '0;
			end
			1: begin
				v = '1;
			end
			2: begin
				v = $urandom_range(0, int'(base) * int'(base));
			end
			3: begin
				p = 64'd1;
				k = $urandom_range(1, 31);
				for (int i = 0; i < k; i++) begin
					if (p * base <= 64'hFFFF_FFFF) begin
						p = p * base;
					end
				end
				v = 32'(p + 64'($urandom_range(0, 2)) - 64'd1);
			end
			4: begin
				v = $urandom_range(0, 255);
			end
			default: begin
				v = $urandom;
			end
		endcase
		return v;
	endfunction

	// push side: random gap, then hold push until the transfer
	task automatic send_value(input logic [31:0] v, input logic [255:0] text);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		value_in <= v;
		do @(posedge clk); while (full);
		if (text != '0) begin
			load_spelled(text);
		end else begin
			expand_digits(v, radix_shadow);
		end
	endtask

	// stop pushing and let every due character come out
	task automatic drain_results();
		push <= 1'b0;
		do @(posedge clk); while (digits_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, then read the radix back
	task automatic program_radix(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		logic [RADIX_W-1:0] v;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// out-of-range radix saturates, other registers ignore the write
		if (addr[PADDR_W-1:2] == REG_RADIX) begin
			v = data[RADIX_W-1:0];
			if (v < RADIX_MIN) begin
				v = RADIX_MIN;
			end
			if (v > RADIX_MAX) begin
				v = RADIX_MAX;
			end
			radix_shadow = v;
		end
		@(posedge clk);
		psel <= 1'b1;
		paddr <= RADIX_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DATA_W'(radix_shadow)) begin
			flag_mismatch($sformatf("radix readback %h, want %h", prdata, radix_shadow));
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// pop side: random stall per character, check each transfer in order
	initial begin
		int          gap;
		digit_xfer_t want;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty !== 1'b0);
			if (digits_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected char %h last %b", digit_char, last_digit));
			end else begin
				want = digits_due.pop_front();
				if (digit_char !== want.ch) begin
					flag_mismatch($sformatf("digit_char %h, want %h", digit_char, want.ch));
				end
				if (last_digit !== want.last) begin
					flag_mismatch($sformatf("last_digit %b, want %b on char %h",
						last_digit, want.last, want.ch));
				end
			end
		end
	end

	initial begin
		logic [31:0] wdata;
		arst_n <= 1'b0;
		push <= 1'b0;
		value_in <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		radix_shadow = RADIX_RESET;

		// directed table: reset radix first, then extremes and saturation
		dir_rows[0]  = mk_row(1'b0, RADIX_ADDR, 32'd0, 32'd0, "0");
		dir_rows[1]  = mk_row(1'b0, RADIX_ADDR, 32'd0, 32'hFFFF_FFFF, "4294967295");
		dir_rows[2]  = mk_row(1'b0, RADIX_ADDR, 32'd0, 32'd7, "7");
		dir_rows[3]  = mk_row(1'b1, RADIX_ADDR, 32'd2, 32'hFFFF_FFFF,
			"11111111111111111111111111111111");
		dir_rows[4]  = mk_row(1'b0, RADIX_ADDR, 32'd0, 32'd0, "0");
		dir_rows[5]  = mk_row(1'b0, RADIX_ADDR, 32'd0, 32'h8000_0000, '0);
		dir_rows[6]  = mk_row(1'b1, RADIX_ADDR, 32'd36, 32'd35, "Z");
		dir_rows[7]  = mk_row(1'b0, RADIX_ADDR, 32'd0, 32'hFFFF_FFFF, "1Z141Z3");
		dir_rows[8]  = mk_row(1'b0, RADIX_ADDR, 32'd0, 32'd36, "10");
		dir_rows[9]  = mk_row(1'b1, RADIX_ADDR, 32'd16, 32'hFFFF_FFFF, "FFFFFFFF");
		dir_rows[10] = mk_row(1'b0, RADIX_ADDR, 32'd0, 32'hDEAD_BEEF, "DEADBEEF");
		// radix below the range saturates to 2
		dir_rows[11] = mk_row(1'b1, RADIX_ADDR, 32'd0, 32'd5, "101");
		dir_rows[12] = mk_row(1'b1, RADIX_ADDR, 32'd1, 32'd2, "10");
		// radix above the range saturates to 36
		dir_rows[13] = mk_row(1'b1, RADIX_ADDR, 32'd37, 32'd10, "A");
		dir_rows[14] = mk_row(1'b1, RADIX_ADDR, 32'd63, 32'd1295, "ZZ");
		// write to an unmapped register leaves radix at 36
		dir_rows[15] = mk_row(1'b1, UNMAPPED_ADDR, 32'd10, 32'd71, "1Z");
		// upper data bits are dropped, radix 5
		dir_rows[16] = mk_row(1'b1, RADIX_ADDR, 32'hFFFF_FFC5, 32'hFFFF_FFFF, '0);
		dir_rows[17] = mk_row(1'b1, RADIX_ADDR, 32'd3, 32'h1234_5678, '0);
		dir_rows[18] = mk_row(1'b1, RADIX_ADDR, 32'd10, 32'd9, "9");
		dir_rows[19] = mk_row(1'b1, RADIX_ADDR, 32'd35, 32'd34, "Y");
		dir_rows[20] = mk_row(1'b1, RADIX_ADDR, 32'd11, 32'h5555_5555, '0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (dir_rows[r].cfg) begin
				drain_results();
				program_radix(dir_rows[r].addr, dir_rows[r].wdata);
			end
			send_value(dir_rows[r].value, dir_rows[r].text);
		end

		// random phases, each under its own radix; the drain before every
		// radix write is the point where the sender waits for all results
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: wdata = 32'(RADIX_MIN);
				1: wdata = 32'(RADIX_MAX);
				default: wdata = $urandom_range(0, 1) ? $urandom_range(2, 36) : $urandom;
			endcase
			drain_results();
			no_idle = (ph == 3 || ph == 6);
			if (ph == 4) begin
				program_radix(UNMAPPED_ADDR, $urandom);
			end
			program_radix(RADIX_ADDR, wdata);
			for (int i = 0; i < PHASE_VALUES; i++) begin
				send_value(random_value(radix_shadow), '0);
			end
		end

		drain_results();
		if (mismatch_count == 0) begin
			$display("** integer_to_radix_digits: PASSED **");
		end else begin
			$display("** integer_to_radix_digits: FAILED **");
		end
		$finish;
	end

endmodule
`default_nettype wire
